[hw/rtl/teoq_pkg.sv]
package teoq_pkg;

  localparam int unsigned DefQueueDepth = 16;
  localparam int unsigned WordWidth     = 64;
  localparam int unsigned TimeWidth     = 32;

  typedef enum logic [1:0] {
    ST_ACCEPTED = 2'd0,
    ST_DROPPED  = 2'd1,
    ST_LISTED   = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  // Stored word: time in [31:0], target in [47:32], type in [63:48].
  typedef struct packed {
    status_e                status;
    logic [WordWidth-1:0]   word;
    logic                   last;
  } res_t;

  function automatic logic [TimeWidth-1:0] time_of(input logic [WordWidth-1:0] w);
    time_of = w[TimeWidth-1:0];
  endfunction

endpackage

[hw/rtl/teoq_store.sv]
module teoq_store import teoq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = DefQueueDepth,
  parameter int unsigned AW          = $clog2(QUEUE_DEPTH)
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AW-1:0]        waddr_i,
  input  logic [WordWidth-1:0] wdata_i,
  input  logic                 re_i,
  input  logic [AW-1:0]        raddr_i,
  output logic [WordWidth-1:0] rdata_o
);

  logic [WordWidth-1:0] mem [QUEUE_DEPTH];
  logic [WordWidth-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/teoq_seq.sv]
module teoq_seq import teoq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = DefQueueDepth,
  parameter int unsigned AW          = $clog2(QUEUE_DEPTH),
  parameter int unsigned CW          = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_kind_i,
  input  logic [WordWidth-1:0] in_word_i,
  output logic                 in_ready_o,
  output logic                 res_valid_o,
  output res_t                 res_o,
  input  logic                 res_ready_i,
  output logic                 we_o,
  output logic [AW-1:0]        waddr_o,
  output logic [WordWidth-1:0] wdata_o,
  output logic                 re_o,
  output logic [AW-1:0]        raddr_o,
  input  logic [WordWidth-1:0] rdata_i
);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_INS_RD  = 7'b0000010,
    S_INS_CMP = 7'b0000100,
    S_INS_PUT = 7'b0001000,
    S_LST_RD  = 7'b0010000,
    S_LST_OUT = 7'b0100000,
    S_RESP    = 7'b1000000
  } state_e;

  state_e               state_q, state_d;
  logic [CW-1:0]        count_q, count_d;
  logic [CW-1:0]        idx_q, idx_d;
  logic [WordWidth-1:0] word_q, word_d;
  status_e              resp_q, resp_d;
  logic                 shift;
  logic                 lst_last;

  // At the slot just below the insertion point, the head moves only on a strictly
  // later time, while any later entry moves on a time at least as large.
  always_comb begin
    if (idx_q == CW'(1)) begin
      shift = time_of(word_q) < time_of(rdata_i);
    end else begin
      shift = time_of(rdata_i) >= time_of(word_q);
    end
  end

  assign lst_last = (CW'(idx_q + CW'(1)) == count_q);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    word_d      = word_q;
    resp_d      = resp_q;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '{status: resp_q, word: '0, last: 1'b1};
    we_o        = 1'b0;
    waddr_o     = idx_q[AW-1:0];
    wdata_o     = word_q;
    re_o        = 1'b0;
    raddr_o     = idx_q[AW-1:0];
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          word_d = in_word_i;
          if (in_kind_i) begin
            idx_d = '0;
            if (count_q == '0) begin
              resp_d  = ST_EMPTY;
              state_d = S_RESP;
            end else begin
              state_d = S_LST_RD;
            end
          end else if (count_q == CW'(QUEUE_DEPTH)) begin
            resp_d  = ST_DROPPED;
            state_d = S_RESP;
          end else if (count_q == '0) begin
            state_d = S_INS_PUT;
          end else begin
            idx_d   = count_q;
            state_d = S_INS_RD;
          end
        end
      end
      S_INS_RD: begin
        re_o    = 1'b1;
        raddr_o = AW'(idx_q - CW'(1));
        state_d = S_INS_CMP;
      end
      S_INS_CMP: begin
        we_o = 1'b1;
        if (shift) begin
          wdata_o = rdata_i;
          idx_d   = CW'(idx_q - CW'(1));
          state_d = (idx_q == CW'(1)) ? S_INS_PUT : S_INS_RD;
        end else begin
          count_d = CW'(count_q + CW'(1));
          resp_d  = ST_ACCEPTED;
          state_d = S_RESP;
        end
      end
      S_INS_PUT: begin
        we_o    = 1'b1;
        waddr_o = '0;
        count_d = CW'(count_q + CW'(1));
        resp_d  = ST_ACCEPTED;
        state_d = S_RESP;
      end
      S_LST_RD: begin
        re_o    = 1'b1;
        state_d = S_LST_OUT;
      end
      S_LST_OUT: begin
        res_o = '{status: ST_LISTED, word: rdata_i, last: lst_last};
        if (res_ready_i) begin
          res_valid_o = 1'b1;
          if (lst_last) begin
            state_d = S_IDLE;
          end else begin
            idx_d   = CW'(idx_q + CW'(1));
            state_d = S_LST_RD;
          end
        end
      end
      S_RESP: begin
        if (res_ready_i) begin
          res_valid_o = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      idx_q   <= '0;
      resp_q  <= ST_ACCEPTED;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      resp_q  <= resp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(QUEUE_DEPTH))
    else $error("entry count exceeds queue depth");

  a_write_only_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we_o |-> (state_q == S_INS_CMP || state_q == S_INS_PUT))
    else $error("store written outside an insert");

  a_cmp_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INS_CMP || state_q == S_INS_RD) |-> idx_q != '0)
    else $error("insert scan ran below the head");

  a_list_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LST_OUT) |-> idx_q < count_q)
    else $error("listing read beyond the stored entries");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> ($past(state_q) == S_INS_CMP ||
                                     $past(state_q) == S_INS_PUT))
    else $error("entry count changed outside an insert");

endmodule

[hw/rtl/time_ordered_event_queue.sv]
// Insert: each stored entry that moves up one slot is read, then written one slot higher;
// the event is then written into its place (slot 0 when it lands at the head) and the
// status follows. A drop on a full queue answers with its status without using the store.
// List: each stored entry is read, then presented; an empty queue answers with a status alone.
// One item is worked on at a time; the next is accepted in the cycle after the last result
// enters the output register. Reset empties the queue; stored words are not cleared.
module time_ordered_event_queue import teoq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = DefQueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // event_time[31:0], event_target[47:32], event_type[63:48]
  input  logic        s_axis_tuser,  // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // out_time[31:0], out_target[47:32], out_type[63:48]
  output logic [1:0]  m_axis_tuser,  // status
  output logic        m_axis_tlast   // last
);

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  logic                 we;
  logic [AW-1:0]        waddr;
  logic [WordWidth-1:0] wdata;
  logic                 re;
  logic [AW-1:0]        raddr;
  logic [WordWidth-1:0] rdata;
  logic                 res_valid;
  logic                 res_ready;
  res_t                 res;
  logic                 out_valid_q;
  res_t                 out_q;

  teoq_store #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .AW         (AW)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  teoq_seq #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .AW         (AW),
    .CW         (CW)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_kind_i  (s_axis_tuser),
    .in_word_i  (s_axis_tdata),
    .in_ready_o (s_axis_tready),
    .res_valid_o(res_valid),
    .res_o      (res),
    .res_ready_i(res_ready),
    .we_o       (we),
    .waddr_o    (waddr),
    .wdata_o    (wdata),
    .re_o       (re),
    .raddr_o    (raddr),
    .rdata_i    (rdata)
  );

  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q.word;
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tlast  = out_q.last;

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;
  import teoq_pkg::*;

  localparam int unsigned Depth      = DefQueueDepth;
  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned TailCycles = 80;
  localparam int unsigned NumRandom  = 150;
  localparam int unsigned LongHold   = 300;
  localparam logic        KindInsert = 1'b0;
  localparam logic        KindList   = 1'b1;

  typedef struct {
    logic        kind;
    logic [31:0] ev_time;
    logic [15:0] ev_target;
    logic [15:0] ev_code;
  } cmd_t;

  typedef struct {
    logic [31:0] ev_time;
    logic [15:0] ev_target;
    logic [15:0] ev_code;
  } event_t;

  typedef struct {
    status_e     status;
    logic [31:0] ev_time;
    logic [15:0] ev_target;
    logic [15:0] ev_code;
    logic        last;
  } answer_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;   // event_time[31:0], event_target[47:32], event_type[63:48]
  logic        s_axis_tuser = 1'b0; // kind
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;        // out_time[31:0], out_target[47:32], out_type[63:48]
  logic [1:0]  m_axis_tuser;        // status
  logic        m_axis_tlast;

  cmd_t    pending_cmds[$];
  event_t  sorted_events[$];
  answer_t expected_answers[$];

  int unsigned cycle_cnt = 0;
  int unsigned cmds_total = 0;
  int unsigned cmds_taken = 0;
  int unsigned answers_seen = 0;
  int unsigned mismatches = 0;
  int unsigned n_accepted = 0;
  int unsigned n_dropped = 0;
  int unsigned n_lists = 0;
  int unsigned send_gap = 0;
  int unsigned recv_stall = 0;
  int unsigned hold_cnt = 0;
  logic        hold_done = 1'b0;
  logic        in_fire = 1'b0;

  time_ordered_event_queue dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .m_axis_tlast
  );

  always #1 clk_i = ~clk_i;

  // In every fourth window of cycle_cnt, pick_gap asks for no idling on either side.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if ((cycle_cnt / 256) % 4 == 3) return 0;
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Times come mostly from a small pool so that equal times are frequent.
  function automatic logic [31:0] pick_time();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 5) return 32'(($urandom_range(0, 7)) << 16);
    if (roll == 5) return 32'h0000_0000;
    if (roll == 6) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  task automatic add_cmd(input logic kind, input logic [31:0] t,
                         input logic [15:0] tgt, input logic [15:0] code);
    cmd_t c;
    c.kind = kind;
    c.ev_time = t;
    c.ev_target = tgt;
    c.ev_code = code;
    pending_cmds.push_back(c);
    cmds_total++;
  endtask

  task automatic push_answer(input status_e st, input event_t ev, input logic last);
    answer_t a;
    a.status = st;
    a.ev_time = ev.ev_time;
    a.ev_target = ev.ev_target;
    a.ev_code = ev.ev_code;
    a.last = last;
    expected_answers.push_back(a);
  endtask

  task automatic queue_model_step(input logic kind, input logic [63:0] data);
    event_t ev;
    event_t blank;
    int     pos;
    ev.ev_time = data[31:0];
    ev.ev_target = data[47:32];
    ev.ev_code = data[63:48];
    blank = '{default: '0};
    if (kind == KindInsert) begin
      if (sorted_events.size() >= Depth) begin
        n_dropped++;
        push_answer(ST_DROPPED, blank, 1'b1);
      end else begin
        // An equal time at the head lands after the head, but an equal
        // time further down lands before that entry.
        pos = sorted_events.size();
        if (sorted_events.size() == 0 || ev.ev_time < sorted_events[0].ev_time) begin
          pos = 0;
        end else begin
          for (int i = 1; i < sorted_events.size(); i++) begin
            if (sorted_events[i].ev_time >= ev.ev_time) begin
              pos = i;
              break;
            end
          end
        end
        sorted_events.insert(pos, ev);
        n_accepted++;
        push_answer(ST_ACCEPTED, blank, 1'b1);
      end
    end else begin
      n_lists++;
      if (sorted_events.size() == 0) begin
        push_answer(ST_EMPTY, blank, 1'b1);
      end else begin
        foreach (sorted_events[i]) begin
          push_answer(ST_LISTED, sorted_events[i], i == sorted_events.size() - 1);
        end
      end
    end
  endtask

  // Results are checked before the input of the same edge is predicted.
  always @(posedge clk_i) begin
    answer_t exp_a;
    in_fire <= s_axis_tvalid && s_axis_tready;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      answers_seen++;
      if (expected_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result: status=%0d data=%h last=%0b",
                   m_axis_tuser, m_axis_tdata, m_axis_tlast);
        end
      end else begin
        exp_a = expected_answers.pop_front();
        if (m_axis_tuser !== exp_a.status || m_axis_tdata[31:0] !== exp_a.ev_time ||
            m_axis_tdata[47:32] !== exp_a.ev_target ||
            m_axis_tdata[63:48] !== exp_a.ev_code || m_axis_tlast !== exp_a.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected status=%0d time=%h target=%h type=%h last=%0b",
                     exp_a.status, exp_a.ev_time, exp_a.ev_target, exp_a.ev_code,
                     exp_a.last);
            $display("          actual   status=%0d time=%h target=%h type=%h last=%0b",
                     m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[47:32],
                     m_axis_tdata[63:48], m_axis_tlast);
          end
        end
      end
    end
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      cmds_taken++;
      queue_model_step(s_axis_tuser, s_axis_tdata);
    end
  end

  always @(negedge clk_i) begin
    cmd_t c;
    logic next_valid;
    if (rst_ni) begin
      if (s_axis_tvalid && !in_fire) begin
        next_valid = 1'b1;
      end else if (send_gap > 0) begin
        send_gap--;
        next_valid = 1'b0;
      end else if (pending_cmds.size() > 0) begin
        c = pending_cmds.pop_front();
        s_axis_tuser <= c.kind;
        s_axis_tdata <= {c.ev_code, c.ev_target, c.ev_time};
        next_valid = 1'b1;
        send_gap = pick_gap();
      end else begin
        next_valid = 1'b0;
      end
      s_axis_tvalid <= next_valid;
    end
  end

  // Once, the receiver backs off for a long stretch so the queue stalls its input.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!hold_done && cmds_taken >= 40) begin
        hold_done = 1'b1;
        hold_cnt = LongHold;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_axis_tready <= 1'b0;
      end else if (recv_stall > 0) begin
        recv_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) recv_stall = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    logic kind;
    // Directed part: empty listing, head and tail placement, equal times at
    // the head and further down, extreme field values, then fill and overflow.
    add_cmd(KindList, 32'h0, 16'h0, 16'h0);
    add_cmd(KindInsert, 32'h0002_0000, 16'h0000, 16'h0000);
    add_cmd(KindInsert, 32'h0002_0000, 16'h0001, 16'h0001);
    add_cmd(KindInsert, 32'h0001_8000, 16'hFFFF, 16'hFFFF);
    add_cmd(KindList, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
    add_cmd(KindInsert, 32'hFFFF_FFFF, 16'h1234, 16'h4321);
    add_cmd(KindInsert, 32'h0002_0000, 16'h0002, 16'h0002);
    add_cmd(KindInsert, 32'h0000_0000, 16'hA5A5, 16'h5A5A);
    add_cmd(KindInsert, 32'hFFFF_FFFF, 16'h5A5A, 16'hA5A5);
    add_cmd(KindList, 32'h0, 16'h0, 16'h0);
    for (int i = 0; i < Depth - 7; i++) begin
      add_cmd(KindInsert, pick_time(), 16'($urandom), 16'($urandom));
    end
    add_cmd(KindList, 32'h0, 16'h0, 16'h0);
    add_cmd(KindInsert, 32'h0000_0000, 16'hFFFF, 16'hFFFF);
    add_cmd(KindList, 32'h0, 16'h0, 16'h0);
    for (int i = 0; i < NumRandom; i++) begin
      kind = ($urandom_range(0, 99) < 55) ? KindInsert : KindList;
      add_cmd(kind, pick_time(), 16'($urandom), 16'($urandom));
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (cmds_taken < cmds_total) @(posedge clk_i);
    while (expected_answers.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    $display("Sent %0d commands: %0d inserts stored, %0d dropped on a full queue, %0d listings.",
             cmds_taken, n_accepted, n_dropped, n_lists);
    $display("Checked %0d results, %0d mismatches, in %0d cycles.",
             answers_seen, mismatches, cycle_cnt);
    if (mismatches == 0 && expected_answers.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/teoq_pkg.sv
hw/rtl/teoq_store.sv
hw/rtl/teoq_seq.sv
hw/rtl/time_ordered_event_queue.sv
verif/tb.sv
